>>> hw/rtl/hblc_pkg.sv
// Shared constants and types of the letter-count heapsort block.
package hblc_pkg;

  localparam int CHAR_W = 8;
  localparam int KEY_W = 10;
  localparam int ID_W = 6;
  localparam int KEY_MAX = 1023;

  localparam int DEF_MAX_RECORDS = 64;
  localparam int DEF_MAX_LEN = 1024;

  localparam logic [CHAR_W-1:0] TARGET_CHAR_RESET = 8'd97;

  // Register index, taken from paddr[2].
  localparam logic REG_TARGET_CHAR = 1'b0;

  // Commands from the loader to the sort engine.
  typedef struct packed {
    logic wr;
    logic start;
    logic drop;
  } sort_cmd_t;

endpackage

>>> hw/rtl/hblc_sorter.sv
// Record memory and heapsort sequencer with the result stream register.
module hblc_sorter #(
  parameter int MAX_RECORDS = hblc_pkg::DEF_MAX_RECORDS,
  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hblc_pkg::sort_cmd_t        cmd,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [hblc_pkg::KEY_W-1:0] wr_key,
  input  logic [CNT_W-1:0]           num,
  output logic                       busy,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,  // record_index[5:0], letter_count[15:6]
  output logic                       m_tlast,
  output logic [0:0]                 m_tuser   // overflowed[0]
);
  import hblc_pkg::*;

  localparam int ENT_W = KEY_W + IDX_W;
  localparam int CHILD_W = IDX_W + 2;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_BSTART = 9'b000000010,
    S_ITEM   = 9'b000000100,
    S_CMP    = 9'b000001000,
    S_PUT    = 9'b000010000,
    S_XSTART = 9'b000100000,
    S_XSWAP  = 9'b001000000,
    S_ERD    = 9'b010000000,
    S_ELD    = 9'b100000000
  } state_t;

  // Entries are {key, id}.
  logic [ENT_W-1:0] mem [MAX_RECORDS];
  logic [ENT_W-1:0] rdata_a, rdata_b;
  logic             we;
  logic [IDX_W-1:0] wa, ra, rb;
  logic [ENT_W-1:0] wd;

  state_t           state, state_next;
  logic [CNT_W-1:0] kk, kk_next;
  logic [CNT_W-1:0] size, size_next;
  logic [CNT_W-1:0] heap_n, heap_n_next;
  logic [CNT_W-1:0] e, e_next;
  logic [IDX_W-1:0] hole, hole_next;
  logic [KEY_W-1:0] item_key, item_key_next;
  logic [IDX_W-1:0] item_id, item_id_next;
  logic             building, building_next;
  logic             drop_l, drop_l_next;

  logic             out_valid;
  logic [KEY_W-1:0] out_key;
  logic [IDX_W-1:0] out_id;
  logic             out_last;
  logic             out_drop;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_a <= mem[ra];
    rdata_b <= mem[rb];
  end

  always_comb begin
    logic [CHILD_W-1:0] left, right, nl, nr;
    logic [KEY_W-1:0]   lk, rk, bkey;
    logic               right_ok, go_left, go_right;
    logic [IDX_W-1:0]   child;
    logic [ENT_W-1:0]   centry;
    state_t             done_state;

    left = {1'b0, hole, 1'b1};
    right = left + CHILD_W'(1);
    lk = rdata_a[ENT_W-1:IDX_W];
    rk = rdata_b[ENT_W-1:IDX_W];
    right_ok = right < CHILD_W'(size);
    go_left = item_key < lk;
    bkey = go_left ? lk : item_key;
    go_right = right_ok && (bkey < rk);
    child = go_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
    centry = go_right ? rdata_b : rdata_a;
    nl = {1'b0, child, 1'b1};
    nr = nl + CHILD_W'(1);
    done_state = building ? S_BSTART : S_XSTART;

    state_next = state;
    kk_next = kk;
    size_next = size;
    heap_n_next = heap_n;
    e_next = e;
    hole_next = hole;
    item_key_next = item_key;
    item_id_next = item_id;
    building_next = building;
    drop_l_next = drop_l;
    we = 1'b0;
    wa = hole;
    wd = {item_key, item_id};
    ra = left[IDX_W-1:0];
    rb = right[IDX_W-1:0];
    out_load = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd.wr) begin
          we = 1'b1;
          wa = wr_addr;
          wd = {wr_key, wr_addr};
        end
        if (cmd.start) begin
          heap_n_next = num;
          size_next = num;
          kk_next = num >> 1;
          building_next = 1'b1;
          drop_l_next = cmd.drop;
          state_next = S_BSTART;
        end
      end
      S_BSTART: begin
        if (kk == '0) begin
          kk_next = heap_n;
          building_next = 1'b0;
          state_next = S_XSTART;
        end else begin
          hole_next = IDX_W'(kk - CNT_W'(1));
          kk_next = kk - CNT_W'(1);
          ra = IDX_W'(kk - CNT_W'(1));
          state_next = S_ITEM;
        end
      end
      S_ITEM: begin
        item_key_next = rdata_a[ENT_W-1:IDX_W];
        item_id_next = rdata_a[IDX_W-1:0];
        // A leaf stays where it is.
        if (left >= CHILD_W'(size)) begin
          state_next = done_state;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (!(go_left || go_right)) begin
          state_next = done_state;
        end else begin
          // The larger child moves up into the hole.
          wd = centry;
          hole_next = child;
          ra = nl[IDX_W-1:0];
          rb = nr[IDX_W-1:0];
          if (nl >= CHILD_W'(size)) begin
            state_next = S_PUT;
          end
        end
      end
      S_PUT: begin
        we = 1'b1;
        state_next = done_state;
      end
      S_XSTART: begin
        if (kk < CNT_W'(2)) begin
          e_next = '0;
          state_next = S_ERD;
        end else begin
          ra = '0;
          rb = IDX_W'(kk - CNT_W'(1));
          state_next = S_XSWAP;
        end
      end
      S_XSWAP: begin
        // The root goes to the end; the last entry sifts down from the root.
        we = 1'b1;
        wa = IDX_W'(kk - CNT_W'(1));
        wd = rdata_a;
        item_key_next = rdata_b[ENT_W-1:IDX_W];
        item_id_next = rdata_b[IDX_W-1:0];
        size_next = kk - CNT_W'(1);
        kk_next = kk - CNT_W'(1);
        hole_next = '0;
        ra = IDX_W'(1);
        rb = IDX_W'(2);
        if (kk - CNT_W'(1) <= CNT_W'(1)) begin
          state_next = S_PUT;
        end else begin
          state_next = S_CMP;
        end
      end
      S_ERD: begin
        ra = e[IDX_W-1:0];
        if (!out_valid || m_tready) begin
          state_next = S_ELD;
        end
      end
      S_ELD: begin
        out_load = 1'b1;
        if (e + CNT_W'(1) == heap_n) begin
          state_next = S_IDLE;
        end else begin
          e_next = e + CNT_W'(1);
          state_next = S_ERD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kk <= kk_next;
    size <= size_next;
    heap_n <= heap_n_next;
    e <= e_next;
    hole <= hole_next;
    item_key <= item_key_next;
    item_id <= item_id_next;
    building <= building_next;
    drop_l <= drop_l_next;
    if (out_load) begin
      out_key <= rdata_a[ENT_W-1:IDX_W];
      out_id <= rdata_a[IDX_W-1:0];
      out_last <= (e + CNT_W'(1) == heap_n);
      out_drop <= drop_l;
    end
  end

  assign busy = (state != S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata = {out_key, ID_W'(out_id)};
  assign m_tlast = out_last;
  assign m_tuser = out_drop;

endmodule

>>> hw/rtl/heapsort_by_letter_count_top.sv
// Top level of the letter-count heapsort block: register port, loader, sort engine.
//
// Characters stream in at one word per cycle. Each string's count of the
// configured character (saturated at the smaller of MAX_LEN-1 and 1023) is
// stored with its arrival number; strings beyond MAX_RECORDS are dropped and
// flagged on every result of the set. On the word that ends the set the input
// stalls while an in-place heapsort runs over the record memory (one write and
// two registered read ports). Results then leave in ascending count order, each
// result read from the record memory while the one before it waits in the output
// register. Input is taken again once the last result is in the output register.
module heapsort_by_letter_count_top #(
  parameter int MAX_RECORDS = hblc_pkg::DEF_MAX_RECORDS,
  parameter int MAX_LEN = hblc_pkg::DEF_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic        s_tlast,   // end_of_string
  input  logic [0:0]  s_tuser,   // end_of_set[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // record_index[5:0], letter_count[15:6]
  output logic        m_tlast,   // last_result
  output logic [0:0]  m_tuser,   // overflowed[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hblc_pkg::*;

  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int LIMIT = (MAX_LEN - 1 < KEY_MAX) ? (MAX_LEN - 1) : KEY_MAX;

  logic [CHAR_W-1:0] target_char;
  logic [KEY_W-1:0]  running_count;
  logic [CNT_W-1:0]  record_count;
  logic              drop_flag;

  logic              accept, close, room, hit, busy;
  logic [KEY_W-1:0]  count_new;
  sort_cmd_t         cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_CHAR) ? {24'd0, target_char} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_char <= TARGET_CHAR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_CHAR)) begin
      target_char <= pwdata[CHAR_W-1:0];
    end
  end

  assign s_tready = !busy;
  assign accept = s_tvalid && s_tready;
  // The end of the set also closes the string in progress.
  assign close = s_tlast || s_tuser[0];
  assign room = record_count < CNT_W'(MAX_RECORDS);
  assign hit = (s_tdata == target_char) && (running_count < KEY_W'(LIMIT));
  assign count_new = running_count + KEY_W'(hit);

  assign cmd.wr = accept && close && room;
  assign cmd.start = accept && s_tuser[0];
  assign cmd.drop = drop_flag || (close && !room);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      record_count <= '0;
      drop_flag <= 1'b0;
    end else if (accept) begin
      if (s_tuser[0]) begin
        running_count <= '0;
        record_count <= '0;
        drop_flag <= 1'b0;
      end else if (close) begin
        running_count <= '0;
        if (room) begin
          record_count <= record_count + CNT_W'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end else begin
        running_count <= count_new;
      end
    end
  end

  hblc_sorter #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_sorter (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wr_addr  (record_count[IDX_W-1:0]),
    .wr_key   (count_new),
    .num      (record_count + CNT_W'(cmd.wr)),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
